FILE: rtl/core/tdns_pkg.sv
// Package for top_degree_nodes_select: field widths, slot and control types,
// controller state encoding. No dependencies.
package tdns_pkg;

  localparam int NODES     = 32;
  localparam int TOP_COUNT = 5;

  localparam int RowW  = 32;
  localparam int DegW  = 6;
  localparam int NodeW = 5;
  localparam int RankW = 3;
  localparam int OutDataW = 16;

  // columns at or above NODES are dropped
  localparam logic [RowW-1:0] RowMask =
    (NODES >= RowW) ? {RowW{1'b1}} : RowW'((64'd1 << NODES) - 64'd1);

  typedef struct packed {
    logic [DegW-1:0]  degree;
    logic [NodeW-1:0] node;
    logic             filled;
  } slot_t;

  typedef struct packed {
    logic  ins_en;
    logic  drain_en;
    slot_t new_slot;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

endpackage

FILE: rtl/core/tdns_popcnt.sv
// Degree counter: masks the adjacency row to the node count and counts set bits.
// Depends on tdns_pkg.
module tdns_popcnt
  import tdns_pkg::*;
(
  input  logic [RowW-1:0] row_i,
  output logic [DegW-1:0] degree_o
);

  logic [RowW-1:0] row_m;
  logic [DegW-1:0] sum;

  assign row_m = row_i & RowMask;

  always_comb begin
    sum = '0;
    for (int i = 0; i < RowW; i++) begin
      sum = sum + DegW'(row_m[i]);
    end
  end

  assign degree_o = sum;

endmodule

FILE: rtl/core/tdns_cell.sv
// One ranking cell: holds a slot, takes the new node, its upper neighbor's slot
// on insertion shift, or its lower neighbor's slot on drain. Depends on tdns_pkg.
module tdns_cell
  import tdns_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  slot_t      prev_slot_i,
  input  logic       prev_gt_i,
  input  slot_t      next_slot_i,
  output slot_t      slot_o,
  output logic       gt_o
);

  slot_t slot_q, slot_d;
  logic  gt;

  // slots are kept in descending order, so gt is monotone along the chain
  assign gt = ctrl_i.new_slot.degree > slot_q.degree;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.drain_en) begin
      slot_d = next_slot_i;
    end else if (ctrl_i.ins_en) begin
      if (prev_gt_i) begin
        slot_d = prev_slot_i;
      end else if (gt) begin
        slot_d = ctrl_i.new_slot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;
  assign gt_o   = gt;

endmodule

FILE: rtl/core/tdns_chain.sv
// Row of TOP_COUNT ranking cells; cell 0 holds the highest degree and is the
// drain head. Depends on tdns_pkg and tdns_cell.
module tdns_chain
  import tdns_pkg::*;
#(
  parameter int TopCount = TOP_COUNT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  output slot_t      head_o
);

  slot_t slot   [TopCount];
  logic  gt     [TopCount];
  slot_t prev_s [TopCount];
  logic  prev_g [TopCount];
  slot_t next_s [TopCount];

  for (genvar k = 0; k < TopCount; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign prev_s[k] = '0;
      assign prev_g[k] = 1'b0;
    end else begin : g_mid
      assign prev_s[k] = slot[k-1];
      assign prev_g[k] = gt[k-1];
    end
    if (k == TopCount - 1) begin : g_tail
      assign next_s[k] = '0;
    end else begin : g_body
      assign next_s[k] = slot[k+1];
    end

    tdns_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_i),
      .prev_slot_i (prev_s[k]),
      .prev_gt_i   (prev_g[k]),
      .next_slot_i (next_s[k]),
      .slot_o      (slot[k]),
      .gt_o        (gt[k])
    );
  end

  assign head_o = slot[0];

endmodule

FILE: rtl/core/top_degree_nodes_select.sv
// Top level of top_degree_nodes_select: degree counter, ranking chain, controller.
// Depends on tdns_pkg, tdns_popcnt, tdns_chain.
// Throughput: one row per cycle while idle; a row is counted and inserted in the cycle it is taken.
// After the last row, TOP_COUNT results drain from the head cell, one per cycle when
// m_axis_tready is high, starting the cycle after; no rows are taken in the drain.
// Reset (async, active low) empties all slots and zeroes the node counter.
module top_degree_nodes_select
  import tdns_pkg::*;
#(
  parameter int TopCount = TOP_COUNT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [RowW-1:0]     s_axis_tdata,  // [31:0] row_bits
  input  logic                s_axis_tlast,  // last_row
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // [2:0] rank, [7:3] node, [13:8] degree
  output logic                m_axis_tuser,  // filled
  output logic                m_axis_tlast   // last slot
);

  localparam int CntW = (TopCount > 1) ? $clog2(TopCount) : 1;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NodeW-1:0] row_cnt_q, row_cnt_d;
  logic            s_xfer, m_xfer, cnt_last;
  logic [DegW-1:0] degree;
  cell_ctrl_t      ctrl;
  slot_t           head;

  assign s_xfer   = s_axis_tvalid & s_axis_tready;
  assign m_xfer   = m_axis_tvalid & m_axis_tready;
  assign cnt_last = cnt_q == CntW'(TopCount - 1);

  tdns_popcnt u_popcnt (
    .row_i    (s_axis_tdata),
    .degree_o (degree)
  );

  assign ctrl.ins_en          = s_xfer;
  assign ctrl.drain_en        = m_xfer;
  assign ctrl.new_slot.degree = degree;
  assign ctrl.new_slot.node   = row_cnt_q;
  assign ctrl.new_slot.filled = 1'b1;

  tdns_chain #(
    .TopCount (TopCount)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .head_o (head)
  );

  // next state
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    row_cnt_d = row_cnt_q;
    if (s_xfer) begin
      row_cnt_d = s_axis_tlast ? '0 : row_cnt_q + 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (s_xfer && s_axis_tlast) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (m_xfer) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_DRAIN: m_axis_tvalid = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      row_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  assign m_axis_tdata = {
    (OutDataW - DegW - NodeW - RankW)'(0),
    head.filled ? head.degree : DegW'(0),
    head.filled ? head.node : NodeW'(0),
    RankW'(cnt_q)
  };
  assign m_axis_tuser = head.filled;
  assign m_axis_tlast = cnt_last;

endmodule

FILE: verif/tb_top.sv
// Testbench for top_degree_nodes_select: streams adjacency matrices row by row and checks
// the ranked top-degree slots against an in-bench ranking scoreboard.
// Depends on tdns_pkg and the RTL of top_degree_nodes_select.
`timescale 1ns / 100ps

module tb_top;
  import tdns_pkg::*;

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic [NodeW-1:0] node;
    logic [DegW-1:0]  degree;
    logic             filled;
    logic             last;
  } ranked_slot_t;

  class degree_rank_scoreboard;
    logic [DegW-1:0]  top_deg[TOP_COUNT];
    logic [NodeW-1:0] top_node[TOP_COUNT];
    logic             top_used[TOP_COUNT];
    logic [NodeW-1:0] node_num;
    ranked_slot_t     pending_slots[$];
    int               errors;
    int               rows_taken;
    int               slots_checked;
    int               matrices;

    function void clear_ranking();
      for (int k = 0; k < TOP_COUNT; k++) begin
        top_deg[k]  = '0;
        top_node[k] = '0;
        top_used[k] = 1'b0;
      end
      node_num = '0;
    endfunction

    function void take_row(logic [RowW-1:0] row, logic last_row);
      logic [DegW-1:0] deg;
      bit placed;
      ranked_slot_t s;
      deg = DegW'($countones(row & RowMask));
      placed = 0;
      for (int k = 0; k < TOP_COUNT; k++) begin
        if (!placed && deg > top_deg[k]) begin
          for (int m = TOP_COUNT - 1; m > k; m--) begin
            top_deg[m]  = top_deg[m-1];
            top_node[m] = top_node[m-1];
            top_used[m] = top_used[m-1];
          end
          top_deg[k]  = deg;
          top_node[k] = node_num;
          top_used[k] = 1'b1;
          placed = 1;
        end
      end
      node_num++;
      rows_taken++;
      if (last_row) begin
        for (int k = 0; k < TOP_COUNT; k++) begin
          s.rank   = RankW'(k);
          s.node   = top_used[k] ? top_node[k] : '0;
          s.degree = top_used[k] ? top_deg[k] : '0;
          s.filled = top_used[k];
          s.last   = (k == TOP_COUNT - 1);
          pending_slots.push_back(s);
        end
        matrices++;
        clear_ranking();
      end
    endfunction

    function void check_slot(logic [OutDataW-1:0] data, logic filled, logic last);
      ranked_slot_t exp_s;
      logic [OutDataW-1:0] exp_data;
      if (pending_slots.size() == 0) begin
        errors++;
        $display("%0t: unexpected slot transfer data=%h filled=%b last=%b",
                 $time, data, filled, last);
        return;
      end
      exp_s = pending_slots.pop_front();
      exp_data = OutDataW'({exp_s.degree, exp_s.node, exp_s.rank});
      slots_checked++;
      if (data[RankW-1:0] !== exp_s.rank) begin
        errors++;
        $display("%0t: rank expected %0d actual %0d", $time, exp_s.rank, data[RankW-1:0]);
      end
      if (data[7:3] !== exp_s.node) begin
        errors++;
        $display("%0t: node expected %0d actual %0d", $time, exp_s.node, data[7:3]);
      end
      if (data[13:8] !== exp_s.degree) begin
        errors++;
        $display("%0t: degree expected %0d actual %0d", $time, exp_s.degree, data[13:8]);
      end
      if (data[OutDataW-1:14] !== exp_data[OutDataW-1:14]) begin
        errors++;
        $display("%0t: pad bits expected %b actual %b", $time,
                 exp_data[OutDataW-1:14], data[OutDataW-1:14]);
      end
      if (filled !== exp_s.filled) begin
        errors++;
        $display("%0t: filled expected %b actual %b", $time, exp_s.filled, filled);
      end
      if (last !== exp_s.last) begin
        errors++;
        $display("%0t: last expected %b actual %b", $time, exp_s.last, last);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [RowW-1:0]     s_axis_tdata;  // [31:0] row_bits
  logic                s_axis_tlast;  // last_row
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;  // [2:0] rank, [7:3] node, [13:8] degree
  logic                m_axis_tuser;  // filled
  logic                m_axis_tlast;  // last slot

  degree_rank_scoreboard ranking = new();
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  int longest_matrix = 0;

  top_degree_nodes_select dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver side: random stalls plus an explicit long hold-off
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      ranking.check_slot(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  function automatic logic [RowW-1:0] pick_row();
    logic [RowW-1:0] m;
    int d;
    int r;
    case ($urandom_range(5))
      0: return $urandom;
      1: return '0;
      2: return '1;
      3: return $urandom & $urandom & $urandom;
      4: return $urandom | $urandom | $urandom;
      default: begin
        // small exact degree at a random rotation, to provoke ties
        d = $urandom_range(6);
        r = $urandom_range(RowW - 1);
        m = (RowW'(1) << d) - 1;
        return (m << r) | (m >> (RowW - r));
      end
    endcase
  endfunction

  task automatic send_row(input logic [RowW-1:0] row, input logic last_row);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = row;
    s_axis_tlast  = last_row;
    do @(posedge clk_i); while (!s_axis_tready);
    ranking.take_row(row, last_row);
    @(negedge clk_i);
  endtask

  task automatic send_matrix(input int rows);
    for (int i = 0; i < rows; i++)
      send_row(pick_row(), i == rows - 1);
    if (rows > longest_matrix)
      longest_matrix = rows;
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (ranking.pending_slots.size() != 0)
      @(negedge clk_i);
  endtask

  int phase_rows;
  int rows;
  int idle_set[4]  = '{0, 84, 0, 12};
  int stall_set[4] = '{0, 0, 84, 12};

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    ranking.clear_ranking();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // shift-out of low entries, tie keeps earlier node, zero degree stays out
    send_row(32'hFFFF_FFFF, 1'b0);
    send_row(32'h0000_0000, 1'b0);
    send_row(32'h0000_0001, 1'b0);
    send_row(32'h0000_0003, 1'b0);
    send_row(32'h0000_0003, 1'b0);
    send_row(32'h8000_0000, 1'b0);
    send_row(32'h0000_000F, 1'b0);
    send_row(32'h0000_FFFF, 1'b1);
    // single-row matrices: all slots empty, then one slot filled; then a three-row matrix
    send_row(32'h0000_0000, 1'b1);
    send_row(32'hFFFF_FFFF, 1'b1);
    send_row(32'h5555_5555, 1'b0);
    send_row(32'hAAAA_AAAA, 1'b0);
    send_row(32'h0000_0001, 1'b1);
    wait_drained();

    // long receiver hold-off while the sender keeps offering rows
    hold_left = 150;
    send_matrix(6);
    send_matrix(6);
    wait_drained();
    repeat (20) @(negedge clk_i);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_set[p];
      stall_pct     = stall_set[p];
      phase_rows    = 0;
      send_matrix($urandom_range(33, 40));  // node counter wraps
      while (phase_rows < 40) begin
        case ($urandom_range(9))
          0, 1:    rows = $urandom_range(9, 31);
          2:       rows = NODES;
          default: rows = $urandom_range(1, 8);
        endcase
        send_matrix(rows);
        phase_rows += rows;
      end
      wait_drained();
    end

    stall_pct = 0;
    repeat (20) @(posedge clk_i);
    $display("covered %0d rows in %0d matrices (longest %0d rows), %0d slots checked",
             ranking.rows_taken, ranking.matrices, longest_matrix, ranking.slots_checked);
    $display("idle/stall phases, long output hold-off and sender pause included");
    if (ranking.errors == 0 && ranking.pending_slots.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tdns_pkg.sv
rtl/core/tdns_popcnt.sv
rtl/core/tdns_cell.sv
rtl/core/tdns_chain.sv
rtl/core/top_degree_nodes_select.sv
verif/tb_top.sv
